// ===== src/ooct_pkg.sv =====
`default_nettype none

package ooct_pkg;

    localparam int BLOCK_BITS    = 64;
    localparam int WINDOW_BLOCKS = 4;
    localparam int SEQ_BITS      = 32;
    localparam int BIT_W         = $clog2(BLOCK_BITS);
    localparam int SLOT_W        = $clog2(WINDOW_BLOCKS);
    localparam int WINDOW_SPAN   = WINDOW_BLOCKS * BLOCK_BITS;

    typedef logic [BLOCK_BITS-1:0] t_block;
    typedef logic [SEQ_BITS-1:0]   t_seq;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [BIT_W-1:0]      t_bit;

    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_MARK       = 2'd1,
        OP_QUERY      = 2'd2,
        OP_QUERY_UPTO = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALREADY    = 3'd1,
        ST_OUTSIDE    = 3'd2,
        ST_NOT_ISSUED = 3'd3,
        ST_EXHAUSTED  = 3'd4
    } t_status;

    // ring slot arithmetic, modulo WINDOW_BLOCKS
    function automatic t_slot slot_add(t_slot a, t_slot b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(WINDOW_BLOCKS)) begin
            s = s - (SLOT_W+1)'(WINDOW_BLOCKS);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/out_of_order_completion_tracker_top.sv =====
`default_nettype none

// Out-of-order completion tracker.
// Hands out rising sequence numbers (from 1) and records their completion,
// in any order, in a ring of bitmap blocks held in a one-read, one-write RAM.
// Command channel: i_op / i_seq are taken on a clock edge with start high
// and busy low. Ops: allocate, mark complete, query one, query all up to.
// Result channel: o_valid pulses for exactly one cycle with o_answer,
// o_seq_out and o_status; the receiver cannot stall, so every result is
// taken on the edge that ends its cycle.
// Steps per item: allocate, rejected and out-of-window items are answered
// from registers set at the accept edge; query one reads its block, then
// answers; mark complete reads its block, writes the bit (or reports it
// already marked), then slides: it reads the head block and, while it is
// full, clears it and moves the window on. Query up to reads blocks from
// the head until the target block or one that is not full. busy stays high
// for every item that reads the RAM, so a new item waits for the last one,
// but may be taken in the cycle its result is shown. Window state after
// reset: base 0, number 0 treated as complete, next number 1. The RAM
// itself is not cleared; per-block valid flops make an unwritten block
// read as its reset contents, so no clearing pass.
module out_of_order_completion_tracker_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       i_op,
    input  wire ooct_pkg::t_seq   i_seq,
    output logic                  busy,
    output logic                  o_valid,
    output logic                  o_answer,
    output ooct_pkg::t_seq        o_seq_out,
    output logic [2:0]            o_status
);
    import ooct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_QRY   = 6'b000010,
        S_MARK  = 6'b000100,
        S_SLRD  = 6'b001000,
        S_SLCHK = 6'b010000,
        S_PFX   = 6'b100000
    } t_state;

    // bitmap RAM and per-block written flags
    t_block mem [WINDOW_BLOCKS];
    logic [WINDOW_BLOCKS-1:0] r_ent_vld;
    t_block r_rd_data;
    logic   r_rd_vld;
    t_slot  r_rd_slot;

    t_state r_state, n_state;
    t_slot  r_head, n_head;
    t_seq   r_base, n_base;
    t_seq   r_next, n_next;
    t_slot  r_blk, n_blk;
    t_bit   r_bit, n_bit;
    t_slot  r_cnt, n_cnt;

    logic    r_valid, n_valid;
    logic    r_answer, n_answer;
    t_seq    r_seq_out, n_seq_out;
    t_status r_status, n_status;

    t_slot  rd_addr;
    logic   we;
    t_slot  wr_addr;
    t_block wr_data;

    t_block rd_word;
    t_block bit_mask;
    t_block pre_mask;
    t_seq   off;
    t_op    op_in;
    logic   accept;

    assign accept = start && (r_state == S_IDLE);
    assign op_in  = t_op'(i_op);
    assign off    = i_seq - r_base;

    // unwritten block reads as reset contents: bit 0 of slot 0 set
    assign rd_word  = r_rd_vld ? r_rd_data :
                      ((r_rd_slot == '0) ? t_block'(1) : '0);
    assign bit_mask = t_block'(1) << r_bit;
    assign pre_mask = {BLOCK_BITS{1'b1}} >> (BIT_W'(BLOCK_BITS - 1) - r_bit);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_base    = r_base;
        n_next    = r_next;
        n_blk     = r_blk;
        n_bit     = r_bit;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_answer  = r_answer;
        n_seq_out = r_seq_out;
        n_status  = r_status;
        rd_addr   = r_head;
        we        = 1'b0;
        wr_addr   = r_head;
        wr_data   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_blk     = off[BIT_W +: SLOT_W];
                    n_bit     = off[BIT_W-1:0];
                    n_cnt     = '0;
                    n_answer  = 1'b0;
                    n_status  = ST_OK;
                    n_seq_out = r_next - t_seq'(1);
                    if (op_in == OP_ALLOC) begin
                        n_valid = 1'b1;
                        if (r_next == '1) begin
                            n_status = ST_EXHAUSTED;
                        end else begin
                            n_seq_out = r_next;
                            n_next    = r_next + t_seq'(1);
                        end
                    end else if ((i_seq == '0) || (i_seq >= r_next)) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOT_ISSUED;
                    end else if (i_seq < r_base) begin
                        n_valid = 1'b1;
                        if (op_in == OP_MARK) begin
                            n_status = ST_ALREADY;
                        end else begin
                            n_answer = 1'b1;
                        end
                    end else if (off >= SEQ_BITS'(WINDOW_SPAN)) begin
                        n_valid = 1'b1;
                        if (op_in == OP_MARK) begin
                            n_status = ST_OUTSIDE;
                        end
                    end else begin
                        case (op_in)
                            OP_MARK: begin
                                rd_addr = slot_add(r_head, off[BIT_W +: SLOT_W]);
                                n_state = S_MARK;
                            end
                            OP_QUERY: begin
                                rd_addr = slot_add(r_head, off[BIT_W +: SLOT_W]);
                                n_state = S_QRY;
                            end
                            default: begin
                                rd_addr = r_head;
                                n_state = S_PFX;
                            end
                        endcase
                    end
                end
            end
            S_QRY: begin
                n_answer = |(rd_word & bit_mask);
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            S_MARK: begin
                if (|(rd_word & bit_mask)) begin
                    n_status = ST_ALREADY;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    we      = 1'b1;
                    wr_addr = slot_add(r_head, r_blk);
                    wr_data = rd_word | bit_mask;
                    n_state = S_SLRD;
                end
            end
            S_SLRD: begin
                rd_addr = r_head;
                n_state = S_SLCHK;
            end
            S_SLCHK: begin
                if (&rd_word) begin
                    // head block full: retire it and move the window on
                    we      = 1'b1;
                    wr_addr = r_head;
                    wr_data = '0;
                    n_head  = slot_add(r_head, t_slot'(1));
                    n_base  = r_base + t_seq'(BLOCK_BITS);
                    n_state = S_SLRD;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PFX: begin
                if (r_cnt == r_blk) begin
                    n_answer = ((rd_word & pre_mask) == pre_mask);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (!(&rd_word)) begin
                    n_answer = 1'b0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + t_slot'(1);
                    rd_addr = slot_add(r_head, r_cnt + t_slot'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // bitmap RAM, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_slot <= rd_addr;
        r_rd_vld  <= r_ent_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_base    <= '0;
            r_next    <= t_seq'(1);
            r_valid   <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_base  <= n_base;
            r_next  <= n_next;
            r_valid <= n_valid;
            if (we) begin
                r_ent_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk     <= n_blk;
        r_bit     <= n_bit;
        r_cnt     <= n_cnt;
        r_answer  <= n_answer;
        r_seq_out <= n_seq_out;
        r_status  <= n_status;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_answer  = r_answer;
    assign o_seq_out = r_seq_out;
    assign o_status  = r_status;

endmodule

`default_nettype wire

// ===== tb/out_of_order_completion_tracker_top_tb.sv =====
`timescale 1ns / 1ps

module out_of_order_completion_tracker_top_tb;

    import ooct_pkg::*;

    // Watchdog: cycles with neither a command nor a result transfer.
    // The limit is ample for the slowest item (mark with a four-block slide)
    // and the longest sender gap.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_ITEMS     = 820;
    localparam int RUN_AHEAD      = 270;   // allocations past the window span
    localparam int ALLOC_SPAN     = 180;   // keeps normal traffic inside the window
    localparam int TAIL_CYCLES    = 16;

    // One result as it appears on the result ports.
    typedef struct packed {
        logic    answer;
        t_seq    seq_out;
        t_status status;
    } t_tracker_res;

    // One row of the directed table; res is only used where typed is set.
    typedef struct packed {
        t_op          op;
        t_seq         seq;
        logic         typed;
        t_tracker_res res;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic [1:0] i_op = OP_ALLOC;
    t_seq i_seq   = '0;

    logic       busy;
    logic       o_valid;
    logic       o_answer;
    t_seq       o_seq_out;
    logic [2:0] o_status;

    out_of_order_completion_tracker_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_op      (i_op),
        .i_seq     (i_seq),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_answer  (o_answer),
        .o_seq_out (o_seq_out),
        .o_status  (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Tracker state as the testbench sees it: completion ring, head slot,
    // window base (number at bit 0 of the head block) and next number.
    t_block win_bits [WINDOW_BLOCKS];
    t_slot  win_head;
    t_seq   win_base;
    t_seq   issue_next;

    t_tracker_res pending_res [$];   // results owed by the block, oldest first
    t_dir_row     dir_tab [$];

    // Stimulus-side bookkeeping: numbers handed out but not yet marked.
    t_seq open_nums [$];
    t_seq gen_next;

    int mismatch_cnt = 0;
    int idle_cycles  = 0;

    function automatic void add_row(input t_dir_row row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    function automatic void add_open(input t_seq num);
        open_nums.insert(open_nums.size(), num);
    endfunction

    function automatic t_slot slot_at(input int blk);
        return t_slot'((int'(win_head) + blk) % WINDOW_BLOCKS);
    endfunction

    // Applies one command to the tracker state and returns its result.
    function automatic t_tracker_res track_cmd(input t_op op, input t_seq seq);
        t_tracker_res r;
        t_seq   off;
        int     blk;
        int     bitn;
        t_slot  s;
        t_block pre;
        logic   ok;
        logic   sliding;
        r.answer  = 1'b0;
        r.status  = ST_OK;
        r.seq_out = issue_next - t_seq'(1);
        if (op == OP_ALLOC) begin
            if (issue_next == '1) begin
                r.status = ST_EXHAUSTED;
            end else begin
                r.seq_out  = issue_next;
                issue_next = issue_next + t_seq'(1);
            end
        end else if (seq == '0 || seq >= issue_next) begin
            r.status = ST_NOT_ISSUED;
        end else if (seq < win_base) begin
            // everything under the base is complete by definition
            if (op == OP_MARK) begin
                r.status = ST_ALREADY;
            end else begin
                r.answer = 1'b1;
            end
        end else begin
            off = seq - win_base;
            if (off >= t_seq'(WINDOW_SPAN)) begin
                if (op == OP_MARK) begin
                    r.status = ST_OUTSIDE;
                end
            end else begin
                blk  = int'(off / BLOCK_BITS);
                bitn = int'(off % BLOCK_BITS);
                s    = slot_at(blk);
                if (op == OP_MARK) begin
                    if (win_bits[s][bitn]) begin
                        r.status = ST_ALREADY;
                    end else begin
                        win_bits[s][bitn] = 1'b1;
                        // slide over every full block at the head
                        sliding = 1'b1;
                        for (int n = 0; n < WINDOW_BLOCKS; n++) begin
                            if (sliding && win_bits[win_head] == '1) begin
                                win_bits[win_head] = '0;
                                win_head = t_slot'((int'(win_head) + 1) % WINDOW_BLOCKS);
                                win_base = win_base + t_seq'(BLOCK_BITS);
                            end else begin
                                sliding = 1'b0;
                            end
                        end
                    end
                end else if (op == OP_QUERY) begin
                    r.answer = win_bits[s][bitn];
                end else begin
                    pre = {BLOCK_BITS{1'b1}} >> (BLOCK_BITS - 1 - bitn);
                    ok  = 1'b1;
                    for (int b = 0; b < blk; b++) begin
                        if (win_bits[slot_at(b)] != '1) ok = 1'b0;
                    end
                    if ((win_bits[s] & pre) != pre) ok = 1'b0;
                    r.answer = ok;
                end
            end
        end
        return r;
    endfunction

    // Drives one command and waits for its transfer; the result it owes is
    // queued at the accepting edge. Called at a rising edge, returns at one.
    task automatic send_cmd(input t_op op, input t_seq seq, input logic typed,
                            input t_tracker_res typed_res);
        t_tracker_res pred;
        start <= 1'b1;
        i_op  <= op;
        i_seq <= seq;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = track_cmd(op, seq);
        pending_res.insert(pending_res.size(), typed ? typed_res : pred);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sender holds off until every owed result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    // Allocation is held back once the oldest open number lags too far,
    // so marks in normal traffic stay within the window.
    function automatic logic may_alloc();
        return open_nums.size() == 0 || (gen_next - open_nums[0]) < t_seq'(ALLOC_SPAN);
    endfunction

    function automatic t_seq recent_num();
        if (gen_next > t_seq'(300)) return gen_next - t_seq'($urandom_range(1, 300));
        return t_seq'($urandom_range(1, gen_next));
    endfunction

    // One random item: mostly allocate / mark traffic, then queries, then noise.
    task automatic send_random();
        int   pick;
        int   idx;
        logic want_alloc;
        t_seq s;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            want_alloc = (pick < 35);
            if (open_nums.size() == 0) want_alloc = 1'b1;
            else if (!may_alloc()) want_alloc = 1'b0;
            if (want_alloc) begin
                send_cmd(OP_ALLOC, '0, 1'b0, '0);
                add_open(gen_next);
                gen_next = gen_next + t_seq'(1);
            end else begin
                // out-of-order completion among the oldest few
                idx = $urandom_range(0, (open_nums.size() < 8 ? open_nums.size() : 8) - 1);
                s   = open_nums[idx];
                open_nums.delete(idx);
                send_cmd(OP_MARK, s, 1'b0, '0);
            end
        end else if (pick < 80) begin
            send_cmd(OP_QUERY, recent_num(), 1'b0, '0);
        end else if (pick < 90) begin
            send_cmd(OP_QUERY_UPTO, recent_num(), 1'b0, '0);
        end else if (pick < 94) begin
            // usually a repeat completion, or one below the base
            send_cmd(OP_MARK, recent_num(), 1'b0, '0);
        end else if (pick < 98 || !may_alloc()) begin
            case ($urandom_range(0, 2))
                0: s = '0;
                1: s = gen_next + t_seq'($urandom_range(0, 5));
                default: s = t_seq'($urandom());
            endcase
            send_cmd(t_op'($urandom_range(1, 3)), s, 1'b0, '0);
        end else begin
            // allocate with junk on the seq port, which must be ignored
            send_cmd(OP_ALLOC, t_seq'($urandom()), 1'b0, '0);
            add_open(gen_next);
            gen_next = gen_next + t_seq'(1);
        end
    endtask

    // Result side: every o_valid cycle is a transfer, checked against the
    // oldest owed result. The watchdog runs here too.
    always @(posedge i_clk) begin : result_check
        t_tracker_res want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_res.size() == 0) begin
                    $error("result transfer with nothing owed");
                    mismatch_cnt++;
                end else begin
                    want = pending_res[0];
                    pending_res.delete(0);
                    if (o_answer !== want.answer) begin
                        $error("answer: expected %0d, got %0d", want.answer, o_answer);
                        mismatch_cnt++;
                    end
                    if (o_seq_out !== want.seq_out) begin
                        $error("seq_out: expected %0h, got %0h", want.seq_out, o_seq_out);
                        mismatch_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatch_cnt++;
                    end
                end
            end
            if ((start && busy === 1'b0) || o_valid === 1'b1) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int burst_left;
        burst_left = 0;

        // tracker state after reset: number 0 counts as complete
        foreach (win_bits[i]) win_bits[i] = '0;
        win_bits[0][0] = 1'b1;
        win_head   = '0;
        win_base   = '0;
        issue_next = t_seq'(1);

        // Directed part. Typed expectations only where obvious after reset;
        // the rest go through the predictor.
        add_row('{OP_QUERY,      32'd0, 1'b1, '{1'b0, 32'd0, ST_NOT_ISSUED}});
        add_row('{OP_MARK,       32'd0, 1'b1, '{1'b0, 32'd0, ST_NOT_ISSUED}});
        add_row('{OP_QUERY_UPTO, 32'd1, 1'b1, '{1'b0, 32'd0, ST_NOT_ISSUED}});
        add_row('{OP_ALLOC,      32'd0, 1'b1, '{1'b0, 32'd1, ST_OK}});
        add_row('{OP_ALLOC,      '1,    1'b1, '{1'b0, 32'd2, ST_OK}});
        add_row('{OP_QUERY,      32'd1, 1'b1, '{1'b0, 32'd2, ST_OK}});
        add_row('{OP_QUERY_UPTO, 32'd2, 1'b1, '{1'b0, 32'd2, ST_OK}});
        add_row('{OP_MARK,       32'd2, 1'b1, '{1'b0, 32'd2, ST_OK}});
        add_row('{OP_QUERY_UPTO, 32'd2, 1'b0, '0});
        add_row('{OP_MARK,       32'd2, 1'b1, '{1'b0, 32'd2, ST_ALREADY}});
        add_row('{OP_QUERY,      32'd2, 1'b0, '0});
        add_row('{OP_MARK,       32'd1, 1'b1, '{1'b0, 32'd2, ST_OK}});
        add_row('{OP_QUERY_UPTO, 32'd2, 1'b1, '{1'b1, 32'd2, ST_OK}});
        add_row('{OP_QUERY,      32'd0, 1'b1, '{1'b0, 32'd2, ST_NOT_ISSUED}});
        add_row('{OP_MARK,       32'd3, 1'b1, '{1'b0, 32'd2, ST_NOT_ISSUED}});
        add_row('{OP_MARK,       '1,    1'b1, '{1'b0, 32'd2, ST_NOT_ISSUED}});
        add_row('{OP_QUERY,      '1,    1'b1, '{1'b0, 32'd2, ST_NOT_ISSUED}});
        add_row('{OP_QUERY_UPTO, '1,    1'b1, '{1'b0, 32'd2, ST_NOT_ISSUED}});
        add_row('{OP_MARK,       32'd1, 1'b1, '{1'b0, 32'd2, ST_ALREADY}});
        add_row('{OP_QUERY_UPTO, 32'd1, 1'b0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_cmd(dir_tab[i].op, dir_tab[i].seq, dir_tab[i].typed, dir_tab[i].res);
            if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 6));
        end
        drain_results();

        // everything issued so far is complete, so no open numbers remain
        gen_next = issue_next;

        // Random part: bursts of transfers with gaps, some bursts gap-free.
        // Counter exhaustion needs 2^32 allocations and is out of reach.
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 2) begin
                // Pause until idle, then allocate well past the window span
                // back to back: the newest number lies beyond the window, so
                // its mark is dropped and a query of it answers 0.
                drain_results();
                repeat (RUN_AHEAD) begin
                    send_cmd(OP_ALLOC, t_seq'($urandom()), 1'b0, '0);
                    add_open(gen_next);
                    gen_next = gen_next + t_seq'(1);
                end
                send_cmd(OP_MARK, open_nums[$], 1'b0, '0);
                send_cmd(OP_QUERY, open_nums[$], 1'b0, '0);
                send_cmd(OP_QUERY_UPTO, open_nums[$], 1'b0, '0);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
            end
            burst_left--;
            send_random();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_res.size() != 0) mismatch_cnt++;

        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
